FILE: rtl/core/dps_pkg.sv
// Shared types and constants of the distribution percentile and sample unit.
// Used by every module of the block but dps_ram; depends on nothing.
package dps_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // field widths
  localparam int CMD_W       = 2;
  localparam int IN_IDX_W    = 8;
  localparam int PROB_W      = 17;
  localparam int BASE_W      = 32;
  localparam int BW_W        = 16;
  localparam int EU_W        = 9;
  localparam int VAL_W       = 41;
  localparam int FRAC_BITS   = 8;

  // derived datapath widths
  localparam int SUM_W  = PROB_W + IDX_W;
  localparam int PROD_W = PROB_W + BW_W;
  localparam int BINV_W = ((BASE_W > IDX_W + BW_W) ? BASE_W : IDX_W + BW_W) + 1;
  localparam int DIV_STEPS = VAL_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_BASE_VALUE   = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH    = 2'd1;
  localparam logic [1:0] REG_ENTRIES_USED = 2'd2;

  localparam logic [BASE_W-1:0] BASE_RESET = '0;
  localparam logic [BW_W-1:0]   BW_RESET   = BW_W'(1);
  localparam logic [EU_W-1:0]   EU_RESET   = EU_W'(256);

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  // classified operation
  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_QUERY,
    OP_SAMPLE
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [IN_IDX_W-1:0] idx;
    logic [PROB_W-1:0]   arg;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic [BASE_W-1:0] base_value;
    logic [BW_W-1:0]   bin_width;
    logic [EU_W-1:0]   entries_used;
  } cfg_t;

endpackage

FILE: rtl/core/dps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module dps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write one word, read one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/dps_front.sv
// Front end: accepts input requests, classifies them and queues them.
// Depends on dps_pkg.
module dps_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dps_pkg::CMD_W-1:0]        cmd_i,
  input  logic [dps_pkg::IN_IDX_W-1:0]     entry_index_i,
  input  logic [dps_pkg::PROB_W-1:0]       entry_prob_i,
  input  logic [dps_pkg::PROB_W-1:0]       quantile_i,
  input  logic [dps_pkg::PROB_W-1:0]       uniform_draw_i,
  output dps_pkg::q_head_t                 head_o,
  input  logic                             pop_i
);

  dps_pkg::q_entry_t                 slot_q [dps_pkg::QUEUE_DEPTH];
  dps_pkg::q_entry_t                 cls;
  logic [dps_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [dps_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [dps_pkg::QCNT_W-1:0]        count_q, count_d;
  logic                              push;
  logic                              pop;

  // classify the request and pick its operand
  always_comb begin
    cls.idx = entry_index_i;
    case (cmd_i)
      dps_pkg::CMD_LOAD: begin
        cls.op  = (int'(entry_index_i) < dps_pkg::TABLE_ENTRIES) ?
                  dps_pkg::OP_LOAD : dps_pkg::OP_NOP;
        cls.arg = entry_prob_i;
      end
      dps_pkg::CMD_QUERY: begin
        cls.op  = dps_pkg::OP_QUERY;
        cls.arg = quantile_i;
      end
      dps_pkg::CMD_SAMPLE: begin
        cls.op  = dps_pkg::OP_SAMPLE;
        cls.arg = uniform_draw_i;
      end
      default: begin
        cls.op  = dps_pkg::OP_NOP;
        cls.arg = '0;
      end
    endcase
  end

  assign in_stall_o = (count_q == dps_pkg::QCNT_W'(dps_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];

  // advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (int'(wr_ptr_q) == dps_pkg::QUEUE_DEPTH - 1) ? '0 :
                 wr_ptr_q + dps_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == dps_pkg::QUEUE_DEPTH - 1) ? '0 :
                 rd_ptr_q + dps_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + dps_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - dps_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // hold queued payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: rtl/core/dps_back.sv
// Back end: owns the probability table, walks it for queries and samples,
// interpolates through a serial divider and holds the result register.
// Depends on dps_pkg and dps_ram.
module dps_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dps_pkg::cfg_t                cfg_i,
  input  dps_pkg::q_head_t             head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dps_pkg::VAL_W-1:0]    value_q8_o,
  output logic                         status_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL,
    ST_BINV,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                            state_q;
  dps_pkg::op_e                      op_q;
  logic [dps_pkg::PROB_W-1:0]        arg_q;
  logic [dps_pkg::IDX_W-1:0]         k_q;
  logic [dps_pkg::IDX_W-1:0]         last_q;
  logic [dps_pkg::IDX_W-1:0]         bidx_q;
  logic [dps_pkg::SUM_W-1:0]         upper_q;
  logic [dps_pkg::PROB_W-1:0]        resid_q;
  logic [dps_pkg::PROB_W-1:0]        diff_q;
  logic [dps_pkg::PROB_W-1:0]        pdiv_q;
  logic [dps_pkg::VAL_W-1:0]         num_q;
  logic [dps_pkg::PROB_W-1:0]        rem_q;
  logic [dps_pkg::DCNT_W-1:0]        dcnt_q;
  logic [dps_pkg::BINV_W-1:0]        binv_q;
  logic                              need_div_q;
  logic                              nobin_q;
  logic                              out_valid_q;
  logic [dps_pkg::VAL_W-1:0]         value_q;
  logic                              status_q;

  logic [dps_pkg::PROB_W-1:0]        p;
  logic [dps_pkg::IDX_W-1:0]         raddr;
  logic                              we;
  logic [dps_pkg::IDX_W-1:0]         last_d;
  logic [dps_pkg::SUM_W-1:0]         upper_sum;
  logic                              q_hit;
  logic                              s_hit;
  logic                              at_last;
  logic [dps_pkg::PROB_W-1:0]        mul_a;
  logic [dps_pkg::PROD_W-1:0]        prod;
  logic [dps_pkg::PROB_W:0]          rem_sh;
  logic                              div_ge;
  logic [dps_pkg::PROB_W:0]          rem_sub;

  // table storage
  dps_ram #(
    .WIDTH (dps_pkg::PROB_W),
    .DEPTH (dps_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (dps_pkg::IDX_W'(head_i.entry.idx)),
    .wdata_i (head_i.entry.arg),
    .raddr_i (raddr),
    .rdata_o (p)
  );

  assign pop_o = (state_q == ST_IDLE) && head_i.valid && !out_valid_q;
  assign we    = pop_o && (head_i.entry.op == dps_pkg::OP_LOAD);

  // prefetch the next entry while walking; entry 0 is read while idle
  assign raddr = (state_q == ST_WALK) ? k_q + dps_pkg::IDX_W'(1) : '0;

  // clamp the number of bins in use to a last index
  always_comb begin
    if (cfg_i.entries_used == '0) begin
      last_d = '0;
    end else if (int'(cfg_i.entries_used) > dps_pkg::TABLE_ENTRIES) begin
      last_d = dps_pkg::IDX_W'(dps_pkg::TABLE_ENTRIES - 1);
    end else begin
      last_d = dps_pkg::IDX_W'(cfg_i.entries_used - dps_pkg::EU_W'(1));
    end
  end

  // walk compare
  assign upper_sum = upper_q + dps_pkg::SUM_W'(p);
  assign q_hit     = upper_sum >= dps_pkg::SUM_W'(arg_q);
  assign s_hit     = (p != '0) && (resid_q <= p);
  assign at_last   = (k_q == last_q);

  // shared multiplier: quantile offset times width, or bin index times width
  assign mul_a = (state_q == ST_MUL) ? diff_q : dps_pkg::PROB_W'(bidx_q);
  assign prod  = dps_pkg::PROD_W'(mul_a) * dps_pkg::PROD_W'(cfg_i.bin_width);

  // one restoring division step
  assign rem_sh  = {rem_q, num_q[dps_pkg::VAL_W-1]};
  assign div_ge  = rem_sh >= {1'b0, pdiv_q};
  assign rem_sub = div_ge ? rem_sh - {1'b0, pdiv_q} : rem_sh;

  assign out_valid_o = out_valid_q;
  assign value_q8_o  = value_q;
  assign status_o    = status_q;

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            op_q       <= head_i.entry.op;
            arg_q      <= head_i.entry.arg;
            resid_q    <= head_i.entry.arg;
            upper_q    <= '0;
            k_q        <= '0;
            last_q     <= last_d;
            need_div_q <= 1'b0;
            nobin_q    <= 1'b0;
            if (head_i.entry.op == dps_pkg::OP_QUERY ||
                head_i.entry.op == dps_pkg::OP_SAMPLE) begin
              state_q <= ST_WALK;
            end else begin
              out_valid_q <= 1'b1;
              value_q     <= '0;
              status_q    <= 1'b0;
            end
          end
        end
        ST_WALK: begin
          if (op_q == dps_pkg::OP_QUERY) begin
            if (q_hit) begin
              if (k_q == '0) begin
                bidx_q  <= '0;
                state_q <= ST_BINV;
              end else begin
                bidx_q     <= k_q - dps_pkg::IDX_W'(1);
                diff_q     <= arg_q - dps_pkg::PROB_W'(upper_q);
                pdiv_q     <= p;
                need_div_q <= (p != '0);
                state_q    <= ST_MUL;
              end
            end else if (at_last) begin
              bidx_q  <= last_q;
              state_q <= ST_BINV;
            end else begin
              upper_q <= upper_sum;
              k_q     <= k_q + dps_pkg::IDX_W'(1);
            end
          end else begin
            if (s_hit) begin
              bidx_q  <= k_q;
              state_q <= ST_BINV;
            end else if (at_last) begin
              nobin_q <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              resid_q <= resid_q - p;
              k_q     <= k_q + dps_pkg::IDX_W'(1);
            end
          end
        end
        ST_MUL: begin
          num_q   <= dps_pkg::VAL_W'({prod, dps_pkg::FRAC_BITS'(0)});
          state_q <= ST_BINV;
        end
        ST_BINV: begin
          binv_q <= dps_pkg::BINV_W'(cfg_i.base_value) + dps_pkg::BINV_W'(prod);
          rem_q  <= '0;
          dcnt_q <= '0;
          state_q <= need_div_q ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          rem_q  <= rem_sub[dps_pkg::PROB_W-1:0];
          num_q  <= {num_q[dps_pkg::VAL_W-2:0], div_ge};
          dcnt_q <= dcnt_q + dps_pkg::DCNT_W'(1);
          if (dcnt_q == dps_pkg::DCNT_W'(dps_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          out_valid_q <= 1'b1;
          status_q    <= nobin_q;
          if (nobin_q) begin
            value_q <= '0;
          end else if (need_div_q) begin
            value_q <= dps_pkg::VAL_W'({binv_q, dps_pkg::FRAC_BITS'(0)}) + num_q;
          end else begin
            value_q <= dps_pkg::VAL_W'({binv_q, dps_pkg::FRAC_BITS'(0)});
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/distribution_percentile_and_sample_unit.sv
// Top level of the distribution percentile and sample unit: configuration
// registers on an APB-style port, front end queue and back end sequencer.
// Depends on dps_pkg, dps_front and dps_back.
//
// Usage:
//   Input requests (cmd_i plus operands) move on in_valid_i / in_stall_o, one
//   result (value_q8_o, status_o) per request on out_valid_o / out_stall_i.
//   A load writes one table entry; a query walks the running sum of the bins
//   in use and interpolates inside the hit bin; a sample subtracts bin
//   probabilities from the draw until it fits.
//   The table walk reads one entry a cycle from the table RAM, and the
//   interpolation runs a 41-step restoring divider, one quotient bit a
//   cycle. The back end works on one request at a time; a two-entry queue
//   in front keeps accepting while it is busy.
//   A finished result stays in the output register while out_stall_i is high;
//   the back end starts the next request only once that register is free,
//   and the queue stalls the input side when it fills.
//   Reset clears the queue, the sequencer and the result valid flag and sets
//   the registers to base 0, bin width 1, 256 bins in use. The table itself
//   is not cleared: load every entry before a query or sample reads it.
//   Registers: base_value at 0x0, bin_width at 0x4, entries_used at 0x8;
//   write them only while the block is idle.
module distribution_percentile_and_sample_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dps_pkg::ADDR_W-1:0]    paddr,
  input  logic [dps_pkg::DATA_W-1:0]    pwdata,
  output logic [dps_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dps_pkg::CMD_W-1:0]     cmd_i,
  input  logic [dps_pkg::IN_IDX_W-1:0]  entry_index_i,
  input  logic [dps_pkg::PROB_W-1:0]    entry_prob_i,
  input  logic [dps_pkg::PROB_W-1:0]    quantile_i,
  input  logic [dps_pkg::PROB_W-1:0]    uniform_draw_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dps_pkg::VAL_W-1:0]     value_q8_o,
  output logic                          status_o
);

  dps_pkg::cfg_t    cfg_q;
  dps_pkg::q_head_t head;
  logic             pop;
  logic             cfg_wr;
  logic [1:0]       reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_value   <= dps_pkg::BASE_RESET;
      cfg_q.bin_width    <= dps_pkg::BW_RESET;
      cfg_q.entries_used <= dps_pkg::EU_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        dps_pkg::REG_BASE_VALUE:   cfg_q.base_value   <= pwdata;
        dps_pkg::REG_BIN_WIDTH:    cfg_q.bin_width    <= pwdata[dps_pkg::BW_W-1:0];
        dps_pkg::REG_ENTRIES_USED: cfg_q.entries_used <= pwdata[dps_pkg::EU_W-1:0];
        default: ;
      endcase
    end
  end

  // read back configuration registers
  always_comb begin
    case (reg_sel)
      dps_pkg::REG_BASE_VALUE:   prdata = cfg_q.base_value;
      dps_pkg::REG_BIN_WIDTH:    prdata = dps_pkg::DATA_W'(cfg_q.bin_width);
      dps_pkg::REG_ENTRIES_USED: prdata = dps_pkg::DATA_W'(cfg_q.entries_used);
      default:                   prdata = '0;
    endcase
  end

  dps_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .entry_index_i  (entry_index_i),
    .entry_prob_i   (entry_prob_i),
    .quantile_i     (quantile_i),
    .uniform_draw_i (uniform_draw_i),
    .head_o         (head),
    .pop_i          (pop)
  );

  dps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_q8_o  (value_q8_o),
    .status_o    (status_o)
  );

endmodule

FILE: rtl/core/dps_checker.sv
// Port-level checks of the distribution percentile and sample unit,
// bound to the top level. Depends on dps_pkg for field widths.
module dps_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [dps_pkg::VAL_W-1:0]  value_q8_o,
  input logic                       status_o
);

  logic [3:0] pend_q, pend_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // track requests accepted but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 4'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_q8_o) && $stable(status_o))
    else $error("stalled result changed");

  // a sample with no bin carries a zero value
  a_nobin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> value_q8_o == '0)
    else $error("no-bin result with nonzero value");

  // no result without an outstanding request
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without a request");

  // an empty block never stalls its input
  a_idle_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == '0 |-> !in_stall_o)
    else $error("input stalled while empty");

endmodule

bind distribution_percentile_and_sample_unit dps_checker u_dps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_q8_o  (value_q8_o),
  .status_o    (status_o)
);

FILE: dv/distribution_percentile_and_sample_unit_tb.sv
// Self-checking testbench for distribution_percentile_and_sample_unit: a directed table,
// then randomized phases under several register settings and idle patterns.
// Depends on dps_pkg and the distribution_percentile_and_sample_unit RTL.
module distribution_percentile_and_sample_unit_tb;
  import dps_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ONE_Q16       = 65536;
  localparam int PROB_MAX      = (1 << PROB_W) - 1;
  localparam int WALK_LATENCY  = TABLE_ENTRIES + 46;
  localparam int PRINT_CAP     = 40;
  localparam int DIRECTED_ROWS = 27;
  localparam int PHASES        = 8;

  typedef enum logic [1:0] {ROW_REQ, ROW_BASE, ROW_WIDTH, ROW_USED} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [IN_IDX_W-1:0] idx;
    logic [PROB_W-1:0]   prob;
    logic [PROB_W-1:0]   quant;
    logic [PROB_W-1:0]   draw;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             status;
  } outcome_t;

  typedef struct packed {
    row_kind_e           kind;
    logic [DATA_W-1:0]   reg_val;
    logic [CMD_W-1:0]    cmd;
    logic [IN_IDX_W-1:0] idx;
    logic [PROB_W-1:0]   prob;
    logic [PROB_W-1:0]   quant;
    logic [PROB_W-1:0]   draw;
    logic                fixed;
    logic [VAL_W-1:0]    want_value;
    logic                want_status;
  } directed_row_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              rand_base;
    logic [BW_W-1:0]   width;
    logic [EU_W-1:0]   used;
    idle_mode_e        mode;
    logic [9:0]        count;
  } phase_t;

  // clock, reset and block ports
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [ADDR_W-1:0]     paddr          = '0;
  logic [DATA_W-1:0]     pwdata         = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i          = '0;
  logic [IN_IDX_W-1:0]   entry_index_i  = '0;
  logic [PROB_W-1:0]     entry_prob_i   = '0;
  logic [PROB_W-1:0]     quantile_i     = '0;
  logic [PROB_W-1:0]     uniform_draw_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [VAL_W-1:0]      value_q8_o;
  logic                  status_o;

  // shadow copy of the table and registers
  logic [PROB_W-1:0] bin_prob [TABLE_ENTRIES];
  bit                loaded   [TABLE_ENTRIES];
  logic [BASE_W-1:0] cfg_base  = BASE_RESET;
  logic [BW_W-1:0]   cfg_width = BW_RESET;
  logic [EU_W-1:0]   cfg_used  = EU_RESET;

  outcome_t awaited_results [$];
  outcome_t oldest;
  int stall_pct        = 0;
  int mismatches       = 0;
  int loads_sent       = 0;
  int queries_sent     = 0;
  int samples_sent     = 0;
  int unused_sent      = 0;
  int settings_written = 0;

  distribution_percentile_and_sample_unit u_dut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("FAIL distribution_percentile_and_sample_unit");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    end
  endtask

  // clamp the bins-in-use register the way the block reads it
  function automatic int bins_active();
    int n;
    n = int'(cfg_used);
    if (n == 0) n = 1;
    if (n > TABLE_ENTRIES) n = TABLE_ENTRIES;
    return n;
  endfunction

  function automatic logic [63:0] bin_point(int i);
    return 64'(cfg_base) + 64'(i) * 64'(cfg_width);
  endfunction

  // walk the running sum and interpolate inside the hit bin
  function automatic logic [63:0] percentile_q8(logic [PROB_W-1:0] q);
    logic [63:0] lower, upper, p;
    lower = '0;
    upper = '0;
    for (int i = 0; i < bins_active(); i++) begin
      p = 64'(bin_prob[i]);
      upper += p;
      if (upper >= 64'(q)) begin
        if (i == 0) return 64'(cfg_base) << FRAC_BITS;
        if (p == 0) return bin_point(i - 1) << FRAC_BITS;
        return (bin_point(i - 1) << FRAC_BITS) + (64'(q) - lower) * 64'(cfg_width) * 64'd256 / p;
      end
      lower += p;
    end
    return bin_point(bins_active() - 1) << FRAC_BITS;
  endfunction

  // subtract nonempty bins from the draw until it fits; -1 when none does
  function automatic int sample_bin(logic [PROB_W-1:0] d);
    logic [63:0] rest;
    rest = 64'(d);
    for (int i = 0; i < bins_active(); i++) begin
      if (bin_prob[i] != 0) begin
        if (rest <= 64'(bin_prob[i])) return i;
        rest -= 64'(bin_prob[i]);
      end
    end
    return -1;
  endfunction

  // apply one request to the shadow state and return its result
  function automatic outcome_t resolve_request(request_t r);
    outcome_t res;
    int k;
    res = '0;
    case (r.cmd)
      CMD_LOAD: begin
        if (int'(r.idx) < TABLE_ENTRIES) begin
          bin_prob[r.idx] = r.prob;
          loaded[r.idx]   = 1'b1;
        end
      end
      CMD_QUERY: res.value = VAL_W'(percentile_q8(r.quant));
      CMD_SAMPLE: begin
        k = sample_bin(r.draw);
        if (k < 0) res.status = 1'b1;
        else res.value = VAL_W'(bin_point(k) << FRAC_BITS);
      end
      default: ;
    endcase
    return res;
  endfunction

  // first never-loaded entry that the walk of this request would read, or -1
  function automatic int first_unloaded(request_t r);
    logic [63:0] upper, rest;
    upper = '0;
    rest  = 64'(r.draw);
    if (r.cmd == CMD_QUERY) begin
      for (int i = 0; i < bins_active(); i++) begin
        if (!loaded[i]) return i;
        upper += 64'(bin_prob[i]);
        if (upper >= 64'(r.quant)) return -1;
      end
    end else if (r.cmd == CMD_SAMPLE) begin
      for (int i = 0; i < bins_active(); i++) begin
        if (!loaded[i]) return i;
        if (bin_prob[i] != 0) begin
          if (rest <= 64'(bin_prob[i])) return -1;
          rest -= 64'(bin_prob[i]);
        end
      end
    end
    return -1;
  endfunction

  // mostly small probabilities so that walks reach deep into the table
  function automatic logic [PROB_W-1:0] random_prob(int n);
    int pick, cap;
    pick = $urandom_range(0, 99);
    cap  = (2 * ONE_Q16) / n;
    if (cap > PROB_MAX) cap = PROB_MAX;
    if (pick < 15) return '0;
    if (pick < 98) return PROB_W'($urandom_range(0, cap));
    if (pick < 99) return PROB_W'($urandom_range(0, ONE_Q16));
    return PROB_W'($urandom_range(0, PROB_MAX));
  endfunction

  function automatic logic [PROB_W-1:0] random_level();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '0;
    if (pick < 20) return PROB_W'(ONE_Q16);
    if (pick < 30) return PROB_W'($urandom_range(ONE_Q16 + 1, PROB_MAX));
    return PROB_W'($urandom_range(0, ONE_Q16));
  endfunction

  // random request with noise in the unused fields; fill holes before reading them
  function automatic request_t next_random_request();
    request_t r;
    int pick, n, hole;
    n       = bins_active();
    r.cmd   = CMD_UNUSED;
    r.idx   = IN_IDX_W'($urandom);
    r.prob  = PROB_W'($urandom);
    r.quant = PROB_W'($urandom);
    r.draw  = PROB_W'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 30) begin
      r.cmd  = CMD_LOAD;
      r.prob = random_prob(n);
      if ($urandom_range(0, 3) != 0) r.idx = IN_IDX_W'($urandom_range(0, n - 1));
    end else if (pick < 65) begin
      r.cmd   = CMD_QUERY;
      r.quant = random_level();
    end else if (pick < 95) begin
      r.cmd  = CMD_SAMPLE;
      r.draw = random_level();
    end
    hole = first_unloaded(r);
    if (hole >= 0) begin
      r.cmd  = CMD_LOAD;
      r.idx  = IN_IDX_W'(hole);
      r.prob = random_prob(n);
    end
    return r;
  endfunction

  // hold until every awaited result has come; always waits on the clock before checking
  task automatic wait_drained();
    do @(negedge clk_i); while (awaited_results.size() != 0);
  endtask

  // write one register, read it back, and update the shadow copy
  task automatic set_register(logic [1:0] sel, logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] held;
    case (sel)
      REG_BASE_VALUE: begin
        cfg_base = val;
        held     = val;
      end
      REG_BIN_WIDTH: begin
        cfg_width = val[BW_W-1:0];
        held      = DATA_W'(val[BW_W-1:0]);
      end
      default: begin
        cfg_used = val[EU_W-1:0];
        held     = DATA_W'(val[EU_W-1:0]);
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({sel, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== held) report_mismatch("register readback", 64'(prdata), 64'(held));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    settings_written++;
  endtask

  // present one request after a random gap and hold it until accepted
  task automatic send_request(request_t r, outcome_t want, int gap_pct);
    bit taken;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= r.cmd;
    entry_index_i  <= r.idx;
    entry_prob_i   <= r.prob;
    quantile_i     <= r.quant;
    uniform_draw_i <= r.draw;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    awaited_results.push_back(want);
    case (r.cmd)
      CMD_LOAD:   loads_sent++;
      CMD_QUERY:  queries_sent++;
      CMD_SAMPLE: samples_sent++;
      default:    unused_sent++;
    endcase
    @(negedge clk_i);
  endtask

  // stall the result channel at random
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < stall_pct);
  end

  // compare each accepted result with the oldest awaited one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with none awaited", 64'(value_q8_o), '0);
      end else begin
        oldest = awaited_results.pop_front();
        if (value_q8_o !== oldest.value) begin
          report_mismatch("value_q8", 64'(value_q8_o), 64'(oldest.value));
        end
        if (status_o !== oldest.status) begin
          report_mismatch("status", 64'(status_o), 64'(oldest.status));
        end
      end
    end
  end

  initial begin
    directed_row_t plan [DIRECTED_ROWS];
    phase_t        phases [PHASES];
    request_t      r;
    outcome_t      want;
    int            gap_pct;

    foreach (loaded[i]) loaded[i] = 1'b0;

    plan = '{
      // reset settings: loads, unused command, first-bin hits
      '{ROW_REQ, 32'd0, CMD_LOAD, 8'd0, 17'd0, 17'd0, 17'd0, 1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_UNUSED, 8'hFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
        1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_QUERY, 8'd0, 17'd0, 17'd0, 17'd0, 1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_LOAD, 8'd0, 17'd65536, 17'd0, 17'd0, 1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_QUERY, 8'd0, 17'd0, 17'd65536, 17'd0, 1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_SAMPLE, 8'd0, 17'd0, 17'd0, 17'd0, 1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_SAMPLE, 8'd0, 17'd0, 17'd0, 17'd65536, 1'b1, 41'd0, 1'b0},
      // largest base and width over four bins, one empty
      '{ROW_BASE, 32'hFFFF_FFFF, CMD_LOAD, 8'd0, 17'd0, 17'd0, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_WIDTH, 32'h0000_FFFF, CMD_LOAD, 8'd0, 17'd0, 17'd0, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_USED, 32'd4, CMD_LOAD, 8'd0, 17'd0, 17'd0, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_LOAD, 8'd1, 17'd0, 17'd0, 17'd0, 1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_LOAD, 8'd2, 17'd32768, 17'd0, 17'd0, 1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_LOAD, 8'd3, 17'h1FFFF, 17'd0, 17'd0, 1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_LOAD, 8'd0, 17'd16384, 17'd0, 17'd0, 1'b1, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_QUERY, 8'd0, 17'd0, 17'd16384, 17'd0,
        1'b1, 41'hFF_FFFF_FF00, 1'b0},
      '{ROW_REQ, 32'd0, CMD_QUERY, 8'd0, 17'd0, 17'd16385, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_QUERY, 8'd0, 17'd0, 17'd49152, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_QUERY, 8'd0, 17'd0, 17'h1FFFF, 17'd0, 1'b0, 41'd0, 1'b0},
      // three bins: query with no hit, samples that skip and that miss
      '{ROW_USED, 32'd3, CMD_LOAD, 8'd0, 17'd0, 17'd0, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_QUERY, 8'd0, 17'd0, 17'h1FFFF, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_SAMPLE, 8'd0, 17'd0, 17'd0, 17'd16384, 1'b0, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_SAMPLE, 8'd0, 17'd0, 17'd0, 17'd16385, 1'b0, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_SAMPLE, 8'd0, 17'd0, 17'd0, 17'h1FFFF, 1'b1, 41'd0, 1'b1},
      // zero bin width, then zero bins in use
      '{ROW_WIDTH, 32'd0, CMD_LOAD, 8'd0, 17'd0, 17'd0, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_QUERY, 8'd0, 17'd0, 17'd20000, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_USED, 32'd0, CMD_LOAD, 8'd0, 17'd0, 17'd0, 17'd0, 1'b0, 41'd0, 1'b0},
      '{ROW_REQ, 32'd0, CMD_QUERY, 8'd0, 17'd0, 17'd65536, 17'd0, 1'b0, 41'd0, 1'b0}
    };

    phases = '{
      '{32'd0,        1'b1, 16'd37,     9'd8,   IDLE_NONE, 10'd50},
      '{32'd0,        1'b0, 16'd1,      9'd256, IDLE_SEND, 10'd250},
      '{32'hFFFF_FFFF, 1'b0, 16'hFFFF,  9'd511, IDLE_RECV, 10'd80},
      '{32'd0,        1'b1, 16'h1A2B,   9'd1,   IDLE_BOTH, 10'd50},
      '{32'h1234_5678, 1'b0, 16'd0,     9'd16,  IDLE_NONE, 10'd50},
      '{32'd0,        1'b1, 16'd300,    9'd0,   IDLE_SEND, 10'd50},
      '{32'd0,        1'b1, 16'h8001,   9'd300, IDLE_RECV, 10'd60},
      '{32'd0,        1'b1, 16'd7,      9'd64,  IDLE_BOTH, 10'd60}
    };

    // hold reset, then release it
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // walk the directed table
    foreach (plan[k]) begin
      if (plan[k].kind != ROW_REQ) begin
        in_valid_i <= 1'b0;
        wait_drained();
        case (plan[k].kind)
          ROW_BASE:  set_register(REG_BASE_VALUE, plan[k].reg_val);
          ROW_WIDTH: set_register(REG_BIN_WIDTH, plan[k].reg_val);
          default:   set_register(REG_ENTRIES_USED, plan[k].reg_val);
        endcase
      end else begin
        r.cmd   = plan[k].cmd;
        r.idx   = plan[k].idx;
        r.prob  = plan[k].prob;
        r.quant = plan[k].quant;
        r.draw  = plan[k].draw;
        want    = resolve_request(r);
        if (plan[k].fixed) begin
          want.value  = plan[k].want_value;
          want.status = plan[k].want_status;
        end
        send_request(r, want, 0);
      end
    end

    // random phases, each under its own settings and idle pattern
    foreach (phases[p]) begin
      in_valid_i <= 1'b0;
      wait_drained();
      set_register(REG_BASE_VALUE, phases[p].rand_base ? $urandom : phases[p].base);
      set_register(REG_BIN_WIDTH, DATA_W'(phases[p].width));
      set_register(REG_ENTRIES_USED, DATA_W'(phases[p].used));
      gap_pct   = (phases[p].mode == IDLE_SEND) ? 45 : (phases[p].mode == IDLE_BOTH) ? 21 : 0;
      stall_pct = (phases[p].mode == IDLE_RECV) ? 45 : (phases[p].mode == IDLE_BOTH) ? 21 : 0;
      for (int k = 0; k < int'(phases[p].count); k++) begin
        // pause the sender mid-phase until the block has emptied
        if (k == int'(phases[p].count) / 2) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
        r = next_random_request();
        send_request(r, resolve_request(r), gap_pct);
      end
    end

    // drain and let any stray result show up
    in_valid_i <= 1'b0;
    stall_pct = 0;
    wait_drained();
    repeat (WALK_LATENCY) @(posedge clk_i);

    $display("Ran %0d loads, %0d queries, %0d samples and %0d unused commands",
             loads_sent, queries_sent, samples_sent, unused_sent);
    $display("over %0d register writes; %0d mismatches", settings_written, mismatches);
    if (mismatches == 0) begin
      $display("PASS distribution_percentile_and_sample_unit");
    end else begin
      $display("FAIL distribution_percentile_and_sample_unit");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dps_pkg.sv
rtl/core/dps_ram.sv
rtl/core/dps_front.sv
rtl/core/dps_back.sv
rtl/core/distribution_percentile_and_sample_unit.sv
rtl/core/dps_checker.sv
dv/distribution_percentile_and_sample_unit_tb.sv
